FILE: rtl/ckhr_pkg.sv
// Package for the cookie header recognizer: grammar phases, result struct,
// character constants and byte-class functions. No dependencies.
`default_nettype none

package ckhr_pkg;

  localparam int unsigned DEF_MAX_FIELD_BYTES = 4096;

  localparam int unsigned OCTET_W = 8;
  localparam int unsigned LEN_W   = 13;
  localparam int unsigned PAIR_W  = 12;
  localparam int unsigned PIDX_W  = 3;

  localparam logic [PAIR_W-1:0] PAIR_LIMIT = 12'd2048;
  localparam logic [PIDX_W-1:0] PREFIX_LEN = 3'd7;

  localparam logic [OCTET_W-1:0] CH_TAB   = 8'h09;
  localparam logic [OCTET_W-1:0] CH_SPACE = 8'h20;
  localparam logic [OCTET_W-1:0] CH_DQUOTE = 8'h22;
  localparam logic [OCTET_W-1:0] CH_SEMI  = 8'h3B;
  localparam logic [OCTET_W-1:0] CH_EQ    = 8'h3D;
  localparam logic [OCTET_W-1:0] CH_UC_A  = 8'h41;
  localparam logic [OCTET_W-1:0] CH_UC_Z  = 8'h5A;
  localparam logic [OCTET_W-1:0] CASE_OFS = 8'h20;

  typedef enum logic [3:0] {
    PH_PREFIX   = 4'd0,
    PH_OWS      = 4'd1,
    PH_NAME     = 4'd2,
    PH_VALSTART = 4'd3,
    PH_BARE     = 4'd4,
    PH_QUOTED   = 4'd5,
    PH_AFTERQ   = 4'd6,
    PH_SEMI     = 4'd7,
    PH_SPACE    = 4'd8,
    PH_MATCH    = 4'd9,
    PH_FAIL     = 4'd10
  } phase_t;

  typedef struct packed {
    logic              matched;
    logic [LEN_W-1:0]  match_length;
    logic              full_match;
    logic [PAIR_W-1:0] pair_count;
  } res_t;

  function automatic logic is_ws(input logic [OCTET_W-1:0] b);
    return (b == CH_SPACE) || (b == CH_TAB);
  endfunction

  function automatic logic is_tchar(input logic [OCTET_W-1:0] b);
    logic r;
    case (b) inside
      [8'h61:8'h7A], [8'h41:8'h5A], [8'h30:8'h39]: r = 1'b1;
      8'h21, 8'h23, 8'h24, 8'h25, 8'h26, 8'h27, 8'h2A,
      8'h2B, 8'h2D, 8'h2E, 8'h5E, 8'h5F, 8'h60, 8'h7C, 8'h7E: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic is_cookie_octet(input logic [OCTET_W-1:0] b);
    logic r;
    case (b) inside
      8'h21, [8'h23:8'h2B], [8'h2D:8'h3A], [8'h3C:8'h5B], [8'h5D:8'h7E]: r = 1'b1;
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  function automatic logic [OCTET_W-1:0] prefix_char(input logic [PIDX_W-1:0] idx);
    logic [OCTET_W-1:0] c;
    case (idx)
      3'd0:    c = 8'h63;
      3'd1:    c = 8'h6F;
      3'd2:    c = 8'h6F;
      3'd3:    c = 8'h6B;
      3'd4:    c = 8'h69;
      3'd5:    c = 8'h65;
      3'd6:    c = 8'h3A;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/ckhr_parse.sv
// Grammar state machine and counters of the cookie header recognizer.
// Consumes one byte per step and forms the result on the last byte. Uses ckhr_pkg.
`default_nettype none

module ckhr_parse
  import ckhr_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               step,
  input  logic [OCTET_W-1:0] octet,
  input  logic               last,
  output res_t               res
);

  localparam int unsigned PW = $clog2(MAX_FIELD_BYTES + 2);
  localparam logic [PW-1:0] POS_MAX  = PW'(MAX_FIELD_BYTES);
  localparam logic [PW-1:0] POS_OVER = PW'(MAX_FIELD_BYTES + 1);

  phase_t              phase_r;
  logic [PIDX_W-1:0]   pidx_r;
  logic [PW-1:0]       bpos_r;
  logic [PW-1:0]       acc_r;
  logic [PAIR_W-1:0]   pairs_r;
  logic                tso_r;

  phase_t              phase_c, ph_a, ph_f, phase_nxt, fail_ph, av_ph, fin_fail_ph;
  logic [PIDX_W-1:0]   pidx_nxt;
  logic [PW-1:0]       acc_c, acc_a, acc_f, acc_nxt;
  logic [PW-1:0]       pos1, bpos_nxt;
  logic [PAIR_W-1:0]   pairs_nxt;
  logic                tso_c, tso_nxt;
  logic                commit_c, commit_f, commit;
  logic                over, do_fin;
  logic                ws, tc, co, pfx_hit;
  logic [OCTET_W-1:0]  low;

  assign ws   = is_ws(octet);
  assign tc   = is_tchar(octet);
  assign co   = is_cookie_octet(octet);
  assign low  = (octet >= CH_UC_A && octet <= CH_UC_Z) ? octet + CASE_OFS : octet;
  assign pfx_hit = (pidx_r < PREFIX_LEN) && (low == prefix_char(pidx_r));
  assign pos1 = bpos_r + PW'(1);
  assign over = bpos_r >= POS_MAX;
  assign bpos_nxt = over ? POS_OVER : pos1;
  assign do_fin = over || last;
  assign fail_ph = (pairs_r == '0) ? PH_FAIL : PH_MATCH;
  assign av_ph   = (octet == CH_SEMI) ? PH_SEMI : PH_MATCH;
  // a pair committed by this same byte counts at end of field
  assign fin_fail_ph = (pairs_r == '0 && !(commit_c && !over)) ? PH_FAIL : PH_MATCH;

  // next phase for one consumed byte
  always_comb begin
    phase_c = phase_r;
    unique case (phase_r)
      PH_PREFIX: begin
        if (!pfx_hit) phase_c = PH_FAIL;
        else if (pidx_r == PREFIX_LEN - PIDX_W'(1)) phase_c = PH_OWS;
      end
      PH_OWS: begin
        if (tc) phase_c = PH_NAME;
        else if (!ws) phase_c = PH_FAIL;
      end
      PH_NAME: begin
        if (octet == CH_EQ) phase_c = PH_VALSTART;
        else if (!tc) phase_c = fail_ph;
      end
      PH_VALSTART: begin
        if (octet == CH_DQUOTE) phase_c = PH_QUOTED;
        else if (co) phase_c = PH_BARE;
        else phase_c = av_ph;
      end
      PH_BARE: begin
        if (!co) phase_c = av_ph;
      end
      PH_QUOTED: begin
        if (octet == CH_DQUOTE) phase_c = PH_AFTERQ;
        else if (!co) phase_c = fail_ph;
      end
      PH_AFTERQ: phase_c = av_ph;
      PH_SEMI: phase_c = (octet == CH_SPACE) ? PH_SPACE : fail_ph;
      PH_SPACE: phase_c = tc ? PH_NAME : fail_ph;
      PH_MATCH: phase_c = PH_MATCH;
      default: phase_c = PH_FAIL;
    endcase
  end

  // accepted end, trailing-space flag and pair commit for one consumed byte
  always_comb begin
    acc_c    = acc_r;
    tso_c    = tso_r;
    commit_c = 1'b0;
    pidx_nxt = pidx_r;
    unique case (phase_r)
      PH_PREFIX: begin
        if (pfx_hit) pidx_nxt = pidx_r + PIDX_W'(1);
      end
      PH_NAME: begin
        if (octet != CH_EQ && !tc) tso_c = 1'b0;
      end
      PH_VALSTART: begin
        if (octet != CH_DQUOTE) begin
          commit_c = 1'b1;
          if (co) begin
            acc_c = pos1;
          end else if (ws) begin
            acc_c = pos1;
            tso_c = 1'b1;
          end else begin
            acc_c = bpos_r;
          end
        end
      end
      PH_BARE, PH_AFTERQ: begin
        if (co && phase_r == PH_BARE) begin
          acc_c = pos1;
        end else if (ws) begin
          acc_c = pos1;
          tso_c = 1'b1;
        end
      end
      PH_QUOTED: begin
        if (octet == CH_DQUOTE) begin
          commit_c = 1'b1;
          acc_c    = pos1;
        end else if (!co) begin
          tso_c = 1'b0;
        end
      end
      PH_SEMI: begin
        if (octet != CH_SPACE) tso_c = 1'b0;
      end
      PH_SPACE: begin
        if (!tc) tso_c = 1'b0;
      end
      PH_MATCH: begin
        if (tso_r && ws) acc_c = pos1;
        else tso_c = 1'b0;
      end
      default: begin
      end
    endcase
  end

  // end of field: forced on the last byte and on bytes past the length limit
  assign ph_a  = over ? phase_r : phase_c;
  assign acc_a = over ? acc_r : acc_c;

  always_comb begin
    ph_f     = PH_FAIL;
    acc_f    = acc_a;
    commit_f = 1'b0;
    unique case (ph_a) inside
      PH_VALSTART: begin
        ph_f     = PH_MATCH;
        commit_f = 1'b1;
        acc_f    = (bpos_nxt > POS_MAX) ? POS_MAX : bpos_nxt;
      end
      PH_BARE, PH_AFTERQ, PH_MATCH: ph_f = PH_MATCH;
      PH_NAME, PH_QUOTED, PH_SEMI, PH_SPACE: ph_f = fin_fail_ph;
      default: ph_f = PH_FAIL;
    endcase
  end

  assign phase_nxt = do_fin ? ph_f : ph_a;
  assign acc_nxt   = do_fin ? acc_f : acc_a;
  assign tso_nxt   = do_fin ? 1'b0 : tso_c;
  assign commit    = (!over && commit_c) || (do_fin && commit_f);
  assign pairs_nxt = (commit && pairs_r < PAIR_LIMIT) ? pairs_r + PAIR_W'(1) : pairs_r;

  assign res.matched      = (phase_nxt == PH_MATCH);
  assign res.match_length = res.matched ? LEN_W'(acc_nxt) : '0;
  assign res.full_match   = res.matched && (acc_nxt == bpos_nxt);
  assign res.pair_count   = res.matched ? pairs_nxt : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_PREFIX;
      pidx_r  <= '0;
      bpos_r  <= '0;
      acc_r   <= '0;
      pairs_r <= '0;
      tso_r   <= 1'b0;
    end else if (step) begin
      if (last) begin
        phase_r <= PH_PREFIX;
        pidx_r  <= '0;
        bpos_r  <= '0;
        acc_r   <= '0;
        pairs_r <= '0;
        tso_r   <= 1'b0;
      end else begin
        phase_r <= phase_nxt;
        pidx_r  <= pidx_nxt;
        bpos_r  <= bpos_nxt;
        acc_r   <= acc_nxt;
        pairs_r <= pairs_nxt;
        tso_r   <= tso_nxt;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/cookie_header_recognizer.sv
// Top level of the cookie header recognizer: input beat register, parser,
// result register. Uses ckhr_pkg and ckhr_parse.
//
//   channel | beat content                                  | when
//   in_     | octet, last                                   | every header byte
//   out_    | matched, match_length, full_match, pair_count | once, on the last byte
//
// One byte per cycle unless a stalled result holds back a last byte; a result
// is registered as its last byte leaves the input register.
// The grammar state machine updates once per consumed byte.
// Reset is synchronous and active low; it drops any beat in flight.
// A stalled result only holds back a last byte; other bytes keep flowing.
`default_nettype none

module cookie_header_recognizer
  import ckhr_pkg::*;
#(
  parameter int unsigned MAX_FIELD_BYTES = DEF_MAX_FIELD_BYTES
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [OCTET_W-1:0] in_octet,
  input  logic               in_last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               out_matched,
  output logic [LEN_W-1:0]   out_match_length,
  output logic               out_full_match,
  output logic [PAIR_W-1:0]  out_pair_count
);

  logic               in_vld_r;
  logic [OCTET_W-1:0] in_octet_r;
  logic               in_last_r;
  logic               out_vld_r;
  res_t               res_r;
  res_t               res;
  logic               out_free, adv;

  assign out_free = !out_vld_r || out_ready;
  assign adv      = in_vld_r && (!in_last_r || out_free);
  assign in_ready = !in_vld_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      in_vld_r <= 1'b1;
    end else if (adv) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_octet_r <= in_octet;
      in_last_r  <= in_last;
    end
  end

  ckhr_parse #(
    .MAX_FIELD_BYTES(MAX_FIELD_BYTES)
  ) u_parse (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (adv),
    .octet (in_octet_r),
    .last  (in_last_r),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv && in_last_r) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && in_last_r) begin
      res_r <= res;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_matched      = res_r.matched;
  assign out_match_length = res_r.match_length;
  assign out_full_match   = res_r.full_match;
  assign out_pair_count   = res_r.pair_count;

endmodule

`default_nettype wire

FILE: rtl/ckhr_chk.sv
// Port-level checker for the cookie header recognizer, bound to the top level.
// Uses ckhr_pkg.
`default_nettype none

module ckhr_chk
  import ckhr_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               out_valid,
  input logic               out_ready,
  input logic               out_matched,
  input logic [LEN_W-1:0]   out_match_length,
  input logic               out_full_match,
  input logic [PAIR_W-1:0]  out_pair_count
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_matched)
      && $stable(out_match_length) && $stable(out_full_match) && $stable(out_pair_count))
    else $error("result beat changed while stalled");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_matched |->
      out_match_length == '0 && !out_full_match && out_pair_count == '0)
    else $error("fields not zero on a failed match");

  a_match_pairs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_matched |-> out_pair_count != '0)
    else $error("match reported without a pair");

  a_pair_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_pair_count <= PAIR_LIMIT)
    else $error("pair count above saturation limit");

endmodule

bind cookie_header_recognizer ckhr_chk u_ckhr_chk (.*);

`default_nettype wire
